>>> sv/trwq_pkg.sv
// Shared types and codes for the thread ready/wait queue manager.
// No dependencies; every other file imports this package.
package trwq_pkg;

    // Input word: one queue command
    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  slot;
        logic [15:0] thread_id;
    } trwq_in_t;

    // Result word: one answer per command
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot_out;
    } trwq_out_t;

    // Field write enables of the node memory
    typedef struct packed {
        logic key;
        logic nxt;
        logic prv;
        logic memb;
    } trwq_wen_t;

    // Command codes
    localparam logic [1:0] OP_ENQ_READY = 2'd0;
    localparam logic [1:0] OP_ENQ_WAIT  = 2'd1;
    localparam logic [1:0] OP_REM_READY = 2'd2;
    localparam logic [1:0] OP_REM_WAIT  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_BUSY      = 2'd2;

    // Membership codes
    localparam logic [1:0] MEMB_NONE  = 2'd0;
    localparam logic [1:0] MEMB_READY = 2'd1;
    localparam logic [1:0] MEMB_WAIT  = 2'd2;

    // Queue select: index 0 is the ready queue, index 1 the wait queue
    localparam logic Q_READY = 1'b0;
    localparam logic Q_WAIT  = 1'b1;

endpackage

>>> sv/thread_ready_wait_queue_manager.sv
// Thread ready/wait queue manager: two doubly linked queues over a slot pool.
//
// Input channel s_*: one command word per handshake (enqueue ready/wait with a
// slot and thread id, or remove by thread id from ready/wait). Result channel
// m_*: exactly one result word per command (status, slot).
// Commands are handled one at a time by a sequencer around a node memory with
// registered read data. An enqueue checks the slot, writes the new tail entry
// and links the old tail, if any, to it; a remove walks the queue from the head,
// one memory read per entry, then unlinks the match from its neighbours.
// The result word is registered in the sequencer and again in the output register.
// After reset the sequencer sweeps the membership codes to zero, one entry a
// cycle, over all SLOT_COUNT entries with s_ready low; queues start empty.
// A stalled receiver holds the result in the output register; the sequencer
// finishes the next command and waits until that register frees up.
// Depends on trwq_pkg, trwq_node_mem, trwq_ctrl.
module thread_ready_wait_queue_manager #(
    parameter int SLOT_COUNT = 16,
    parameter int ID_BITS    = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  trwq_pkg::trwq_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output trwq_pkg::trwq_out_t m_data
);
    import trwq_pkg::*;

    localparam int KEY_W     = (ID_BITS < 16) ? ID_BITS : 16;
    localparam int SLOT_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int LINK_W    = $clog2(SLOT_COUNT + 1);

    logic                  rd_en;
    logic [SLOT_BITS-1:0]  rd_addr;
    logic [KEY_W-1:0]      rd_key;
    logic [LINK_W-1:0]     rd_next;
    logic [LINK_W-1:0]     rd_prev;
    logic [1:0]            rd_memb;
    trwq_wen_t             wen;
    logic [SLOT_BITS-1:0]  wr_addr;
    logic [KEY_W-1:0]      wr_key;
    logic [LINK_W-1:0]     wr_next;
    logic [LINK_W-1:0]     wr_prev;
    logic [1:0]            wr_memb;

    logic                  res_valid;
    logic                  res_ready;
    trwq_out_t             res_word;

    logic                  m_valid_reg, m_valid_next;
    trwq_out_t             m_data_reg,  m_data_next;

    trwq_node_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .KEY_W      (KEY_W),
        .SLOT_BITS  (SLOT_BITS),
        .LINK_W     (LINK_W)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_next (rd_next),
        .rd_prev (rd_prev),
        .rd_memb (rd_memb),
        .wen     (wen),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_next (wr_next),
        .wr_prev (wr_prev),
        .wr_memb (wr_memb)
    );

    trwq_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .KEY_W      (KEY_W),
        .SLOT_BITS  (SLOT_BITS),
        .LINK_W     (LINK_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_key    (rd_key),
        .rd_next   (rd_next),
        .rd_prev   (rd_prev),
        .rd_memb   (rd_memb),
        .wen       (wen),
        .wr_addr   (wr_addr),
        .wr_key    (wr_key),
        .wr_next   (wr_next),
        .wr_prev   (wr_prev),
        .wr_memb   (wr_memb)
    );

    // Output register: load when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_data_next = res_word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> sv/trwq_node_mem.sv
// Node memory: per-slot thread id, next/prev links and membership code.
// One write port with field enables, one read port with registered data.
// Depends on trwq_pkg.
module trwq_node_mem #(
    parameter int SLOT_COUNT = 16,
    parameter int KEY_W      = 16,
    parameter int SLOT_BITS  = 4,
    parameter int LINK_W     = 5
) (
    input  logic                  aclk,
    input  logic                  rd_en,
    input  logic [SLOT_BITS-1:0]  rd_addr,
    output logic [KEY_W-1:0]      rd_key,
    output logic [LINK_W-1:0]     rd_next,
    output logic [LINK_W-1:0]     rd_prev,
    output logic [1:0]            rd_memb,
    input  trwq_pkg::trwq_wen_t   wen,
    input  logic [SLOT_BITS-1:0]  wr_addr,
    input  logic [KEY_W-1:0]      wr_key,
    input  logic [LINK_W-1:0]     wr_next,
    input  logic [LINK_W-1:0]     wr_prev,
    input  logic [1:0]            wr_memb
);
    import trwq_pkg::*;

    logic [KEY_W-1:0]  key_mem  [SLOT_COUNT];
    logic [LINK_W-1:0] next_mem [SLOT_COUNT];
    logic [LINK_W-1:0] prev_mem [SLOT_COUNT];
    logic [1:0]        memb_mem [SLOT_COUNT];

    logic [KEY_W-1:0]  rd_key_reg;
    logic [LINK_W-1:0] rd_next_reg;
    logic [LINK_W-1:0] rd_prev_reg;
    logic [1:0]        rd_memb_reg;

    // Write selected fields of one entry
    always_ff @(posedge aclk) begin
        if (wen.key) begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wen.nxt) begin
            next_mem[wr_addr] <= wr_next;
        end
        if (wen.prv) begin
            prev_mem[wr_addr] <= wr_prev;
        end
        if (wen.memb) begin
            memb_mem[wr_addr] <= wr_memb;
        end
    end

    // Read one entry, data valid the next cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_key_reg  <= key_mem[rd_addr];
            rd_next_reg <= next_mem[rd_addr];
            rd_prev_reg <= prev_mem[rd_addr];
            rd_memb_reg <= memb_mem[rd_addr];
        end
    end

    assign rd_key  = rd_key_reg;
    assign rd_next = rd_next_reg;
    assign rd_prev = rd_prev_reg;
    assign rd_memb = rd_memb_reg;

endmodule

>>> sv/trwq_ctrl.sv
// Queue sequencer: head/tail registers, list walk, link updates, clearing pass.
// Drives the node memory at most one access a cycle. Depends on trwq_pkg.
module trwq_ctrl #(
    parameter int SLOT_COUNT = 16,
    parameter int KEY_W      = 16,
    parameter int SLOT_BITS  = 4,
    parameter int LINK_W     = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  trwq_pkg::trwq_in_t    in_word,
    output logic                  res_valid,
    input  logic                  res_ready,
    output trwq_pkg::trwq_out_t   res_word,
    output logic                  rd_en,
    output logic [SLOT_BITS-1:0]  rd_addr,
    input  logic [KEY_W-1:0]      rd_key,
    input  logic [LINK_W-1:0]     rd_next,
    input  logic [LINK_W-1:0]     rd_prev,
    input  logic [1:0]            rd_memb,
    output trwq_pkg::trwq_wen_t   wen,
    output logic [SLOT_BITS-1:0]  wr_addr,
    output logic [KEY_W-1:0]      wr_key,
    output logic [LINK_W-1:0]     wr_next,
    output logic [LINK_W-1:0]     wr_prev,
    output logic [1:0]            wr_memb
);
    import trwq_pkg::*;

    localparam logic [LINK_W-1:0]    NULL_LINK = LINK_W'(SLOT_COUNT);
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOT_COUNT - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ENQ_CHK,
        S_ENQ_LINK,
        S_WALK,
        S_UNL_PREV,
        S_UNL_NEXT,
        S_UNL_SELF,
        S_RESP
    } state_t;

    state_t                state_reg,   state_next;
    logic [SLOT_BITS-1:0]  clr_cnt_reg, clr_cnt_next;
    logic                  q_reg,       q_next;
    logic [SLOT_BITS-1:0]  slot_reg,    slot_next;
    logic [KEY_W-1:0]      key_reg,     key_next;
    logic [SLOT_BITS-1:0]  cur_reg,     cur_next;
    logic [LINK_W-1:0]     prv_reg,     prv_next;
    logic [LINK_W-1:0]     nxt_reg,     nxt_next;
    logic [LINK_W-1:0]     head_reg [2];
    logic [LINK_W-1:0]     head_next [2];
    logic [LINK_W-1:0]     tail_reg [2];
    logic [LINK_W-1:0]     tail_next [2];
    trwq_out_t             res_reg,     res_next;

    logic                  in_is_enq;
    logic                  in_q;
    logic                  in_slot_ok;
    logic [LINK_W-1:0]     in_head;

    // Decode the incoming word
    always_comb begin
        in_is_enq = 1'b0;
        in_q      = Q_READY;
        unique case (in_word.opcode)
            OP_ENQ_READY: begin
                in_is_enq = 1'b1;
                in_q      = Q_READY;
            end
            OP_ENQ_WAIT: begin
                in_is_enq = 1'b1;
                in_q      = Q_WAIT;
            end
            OP_REM_READY: begin
                in_q = Q_READY;
            end
            OP_REM_WAIT: begin
                in_q = Q_WAIT;
            end
            default: begin
                in_is_enq = 1'b0;
            end
        endcase
        in_slot_ok = ({28'd0, in_word.slot} < 32'(SLOT_COUNT));
        in_head    = head_reg[in_q];
    end

    // Sequence the clearing pass, then one command at a time: memory read, compare, link writes, result
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        q_next       = q_reg;
        slot_next    = slot_reg;
        key_next     = key_reg;
        cur_next     = cur_reg;
        prv_next     = prv_reg;
        nxt_next     = nxt_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        res_next     = res_reg;

        in_ready  = (state_reg == S_IDLE);
        res_valid = (state_reg == S_RESP);
        rd_en     = 1'b0;
        rd_addr   = cur_reg;
        wen       = '0;
        wr_addr   = cur_reg;
        wr_key    = key_reg;
        wr_next   = NULL_LINK;
        wr_prev   = NULL_LINK;
        wr_memb   = MEMB_NONE;

        unique case (state_reg)
            S_CLEAR: begin
                wen.memb     = 1'b1;
                wr_addr      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_SLOT) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    q_next    = in_q;
                    slot_next = SLOT_BITS'(in_word.slot);
                    key_next  = in_word.thread_id[KEY_W-1:0];
                    if (in_is_enq) begin
                        if (!in_slot_ok) begin
                            res_next   = '{status: ST_BUSY, slot_out: 4'd0};
                            state_next = S_RESP;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = SLOT_BITS'(in_word.slot);
                            state_next = S_ENQ_CHK;
                        end
                    end else if (in_head == NULL_LINK) begin
                        res_next   = '{status: ST_NOT_FOUND, slot_out: 4'd0};
                        state_next = S_RESP;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = in_head[SLOT_BITS-1:0];
                        cur_next   = in_head[SLOT_BITS-1:0];
                        state_next = S_WALK;
                    end
                end
            end
            S_ENQ_CHK: begin
                if (rd_memb != MEMB_NONE) begin
                    res_next   = '{status: ST_BUSY, slot_out: 4'd0};
                    state_next = S_RESP;
                end else begin
                    // Write the new tail entry
                    wen     = '{key: 1'b1, nxt: 1'b1, prv: 1'b1, memb: 1'b1};
                    wr_addr = slot_reg;
                    wr_key  = key_reg;
                    wr_next = NULL_LINK;
                    wr_prev = tail_reg[q_reg];
                    wr_memb = (q_reg == Q_WAIT) ? MEMB_WAIT : MEMB_READY;
                    tail_next[q_reg] = LINK_W'(slot_reg);
                    res_next = '{status: ST_DONE, slot_out: 4'(slot_reg)};
                    if (tail_reg[q_reg] == NULL_LINK) begin
                        head_next[q_reg] = LINK_W'(slot_reg);
                        state_next       = S_RESP;
                    end else begin
                        cur_next   = tail_reg[q_reg][SLOT_BITS-1:0];
                        state_next = S_ENQ_LINK;
                    end
                end
            end
            S_ENQ_LINK: begin
                // Point the old tail at the new entry
                wen.nxt    = 1'b1;
                wr_addr    = cur_reg;
                wr_next    = LINK_W'(slot_reg);
                state_next = S_RESP;
            end
            S_WALK: begin
                if (rd_key == key_reg) begin
                    prv_next   = rd_prev;
                    nxt_next   = rd_next;
                    state_next = S_UNL_PREV;
                end else if (rd_next == NULL_LINK) begin
                    res_next   = '{status: ST_NOT_FOUND, slot_out: 4'd0};
                    state_next = S_RESP;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = rd_next[SLOT_BITS-1:0];
                    cur_next = rd_next[SLOT_BITS-1:0];
                end
            end
            S_UNL_PREV: begin
                if (prv_reg != NULL_LINK) begin
                    wen.nxt = 1'b1;
                    wr_addr = prv_reg[SLOT_BITS-1:0];
                    wr_next = nxt_reg;
                end else begin
                    head_next[q_reg] = nxt_reg;
                end
                state_next = S_UNL_NEXT;
            end
            S_UNL_NEXT: begin
                if (nxt_reg != NULL_LINK) begin
                    wen.prv = 1'b1;
                    wr_addr = nxt_reg[SLOT_BITS-1:0];
                    wr_prev = prv_reg;
                end else begin
                    tail_next[q_reg] = prv_reg;
                end
                state_next = S_UNL_SELF;
            end
            S_UNL_SELF: begin
                // Detach the removed entry
                wen        = '{key: 1'b0, nxt: 1'b1, prv: 1'b1, memb: 1'b1};
                wr_addr    = cur_reg;
                res_next   = '{status: ST_DONE, slot_out: 4'(cur_reg)};
                state_next = S_RESP;
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, clear counter, queue ends, command fields, walk links and the result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            head_reg[0] <= NULL_LINK;
            head_reg[1] <= NULL_LINK;
            tail_reg[0] <= NULL_LINK;
            tail_reg[1] <= NULL_LINK;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
        end
        q_reg    <= q_next;
        slot_reg <= slot_next;
        key_reg  <= key_next;
        cur_reg  <= cur_next;
        prv_reg  <= prv_next;
        nxt_reg  <= nxt_next;
        res_reg  <= res_next;
    end

    assign res_word = res_reg;

    // A queue is empty at both ends or at neither; the head of a queue that
    // loses its last entry empties in S_UNL_PREV, ahead of its tail in S_UNL_NEXT
    a_ready_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_UNL_NEXT) |->
        ((head_reg[0] == NULL_LINK) == (tail_reg[0] == NULL_LINK)))
        else $error("ready queue head/tail disagree on empty");
    a_wait_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_UNL_NEXT) |->
        ((head_reg[1] == NULL_LINK) == (tail_reg[1] == NULL_LINK)))
        else $error("wait queue head/tail disagree on empty");

    // Never read and write the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && (wen != '0) && (rd_addr == wr_addr)))
        else $error("node memory read/write overlap");

    // A failed command reports slot zero
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res_word.status != ST_DONE)) |-> (res_word.slot_out == 4'd0))
        else $error("nonzero slot on failed command");

    // The walk only visits pool slots
    a_walk_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (32'(cur_reg) < 32'(SLOT_COUNT)))
        else $error("walk left the slot pool");

endmodule
